### rtl/binary_chain_transition_swap_defines.svh
// Assertion macros shared by the swap engine RTL.
// Expects clk and arst_n to be visible where a macro is used.
`ifndef BINARY_CHAIN_TRANSITION_SWAP_DEFINES_SVH
`define BINARY_CHAIN_TRANSITION_SWAP_DEFINES_SVH

// Same-cycle implication, switched off while in reset
`define BCTS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcts: implication check failed");

// Next-cycle implication, switched off while in reset
`define BCTS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcts: next-cycle check failed");

`endif

### rtl/bcts_pkg.sv
// Shared widths, command codes and register indexes for the swap engine.
// No dependencies.
package bcts_pkg;

	localparam int unsigned CMD_W      = 2;
	localparam int unsigned IDX_W      = 10;
	localparam int unsigned LEN_W      = 11;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned DEF_MAX_LENGTH = 1024;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SWAP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_LENGTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH_ATTEMPTS = 2'd1;

	localparam logic [LEN_W-1:0] RST_CHAIN_LENGTH   = 11'd1024;
	localparam logic [CNT_W-1:0] RST_BATCH_ATTEMPTS = 16'd1;

endpackage

### rtl/bcts_in_if.sv
// Command channel of the swap engine: valid/ready plus one command item.
// Depends on bcts_pkg.
interface bcts_in_if import bcts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [IDX_W-1:0] index_a;
	logic [IDX_W-1:0] index_b;
	logic             bit_value;

	modport source (output valid, command, index_a, index_b, bit_value, input ready);
	modport sink (input valid, command, index_a, index_b, bit_value, output ready);
endinterface

### rtl/bcts_out_if.sv
// Result channel of the swap engine: valid/ready plus one result item.
// Depends on bcts_pkg.
interface bcts_out_if import bcts_pkg::*; ();
	logic valid;
	logic ready;
	logic read_bit;
	logic swapped;
	logic rejected;
	logic batch_done;

	modport source (output valid, read_bit, swapped, rejected, batch_done, input ready);
	modport sink (input valid, read_bit, swapped, rejected, batch_done, output ready);
endinterface

### rtl/bcts_cfg_if.sv
// Register write channel of the swap engine: valid/ready, index and data.
// Depends on bcts_pkg.
interface bcts_cfg_if import bcts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

### rtl/bcts_chain_mem.sv
// Single-port bit store holding the chain, registered read data.
// No package dependencies.
module bcts_chain_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic          wdata,
	output logic          rdata
);

	logic store [DEPTH];

	// read-first: a write cycle returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			store[addr] <= wdata;
		end
		rdata <= store[addr];
	end

endmodule

### rtl/binary_chain_transition_swap.sv
// Swap engine top: one item in flight. A write passes S_WRITE, a read S_READ and S_EVAL, a
// swap S_READ and S_EVAL, then S_WRITE when exchanged (six reads, then two writes, through the
// single port of the chain memory); rejected, same-index or unused commands go straight to S_FIN.
// Items are taken only in S_IDLE; a waiting result holds the next in S_FIN.
// arst_n clears the registers, the attempt counter and the sequencer; the chain store is
// not cleared and holds nothing defined until written.
`include "binary_chain_transition_swap_defines.svh"

module binary_chain_transition_swap import bcts_pkg::*; #(
	parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	bcts_cfg_if.sink   cfg,
	bcts_in_if.sink    items,
	bcts_out_if.source results
);

	localparam int unsigned AW     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int unsigned XW     = (AW > LEN_W) ? AW : LEN_W;
	localparam int unsigned LCAP   = (MAX_LENGTH < 2047) ? MAX_LENGTH : 2047;
	localparam logic [LEN_W-1:0] LCAP_V = LEN_W'(LCAP);

	localparam logic [2:0] SLOT_A_LO = 3'd0;
	localparam logic [2:0] SLOT_A_HI = 3'd1;
	localparam logic [2:0] SLOT_B_LO = 3'd2;
	localparam logic [2:0] SLOT_B_HI = 3'd3;
	localparam logic [2:0] SLOT_A    = 3'd4;
	localparam logic [2:0] SLOT_B    = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_EVAL  = 5'b00100,
		S_WRITE = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t          state_q;
	logic [LEN_W-1:0] cfg_len_q;
	logic [CNT_W-1:0] cfg_batch_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CMD_W-1:0] cmd_q;
	logic [LEN_W-1:0] a_q;
	logic [LEN_W-1:0] b_q;
	logic [2:0]       slot_q;
	logic [2:0]       last_q;
	logic             wr_second_q;
	logic             wr_a_data_q;
	logic             wr_b_data_q;
	logic             rd_vld_s1;
	logic [2:0]       rd_slot_s1;
	logic [5:0]       nbr_q;
	logic             res_read_q;
	logic             res_swapped_q;
	logic             res_rej_q;
	logic             res_done_q;
	logic             out_valid_q;
	logic             out_read_q;
	logic             out_swapped_q;
	logic             out_rej_q;
	logic             out_done_q;

	logic [LEN_W-1:0] eff_len;
	logic [LEN_W-1:0] len_top;
	logic [LEN_W-1:0] a_ext;
	logic [LEN_W-1:0] b_ext;
	logic             a_in_range;
	logic             a_ok;
	logic             b_ok;
	logic [CNT_W-1:0] cnt_next;
	logic [CNT_W-1:0] limit;
	logic             batch_hit;
	logic             accept;
	logic             out_load;

	state_t           acc_state;
	logic             acc_rej;
	logic [2:0]       acc_slot;
	logic [2:0]       acc_last;

	logic [5:0]       merged;
	logic [1:0]       sum_a;
	logic [1:0]       sum_b;
	logic             adjacent;
	logic             a_below_b;
	logic             swap_ok;

	logic [LEN_W-1:0] addr_idx;
	logic [XW-1:0]    addr_ext;
	logic [AW-1:0]    mem_addr;
	logic             mem_we;
	logic             mem_wdata;
	logic             mem_rdata;

	// ---------------- item checks at transfer ----------------
	assign eff_len    = (cfg_len_q < LCAP_V) ? cfg_len_q : LCAP_V;
	assign len_top    = eff_len - LEN_W'(2);
	assign a_ext      = {1'b0, items.index_a};
	assign b_ext      = {1'b0, items.index_b};
	assign a_in_range = a_ext < eff_len;
	assign a_ok       = (eff_len >= LEN_W'(3)) && (a_ext != '0) && (a_ext <= len_top);
	assign b_ok       = (eff_len >= LEN_W'(3)) && (b_ext != '0) && (b_ext <= len_top);

	assign cnt_next  = cnt_q + CNT_W'(1);
	assign limit     = (cfg_batch_q == '0) ? CNT_W'(1) : cfg_batch_q;
	assign batch_hit = (cnt_next == '0) || (cnt_next >= limit);

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	// where an accepted item goes next
	always_comb begin
		acc_state = S_FIN;
		acc_rej   = 1'b0;
		acc_slot  = SLOT_A_LO;
		acc_last  = SLOT_B;
		case (items.command)
			CMD_WRITE: begin
				if (a_in_range) begin
					acc_state = S_WRITE;
				end else begin
					acc_rej = 1'b1;
				end
			end
			CMD_READ: begin
				if (a_in_range) begin
					acc_slot  = SLOT_A;
					acc_last  = SLOT_A;
					acc_state = S_READ;
				end else begin
					acc_rej = 1'b1;
				end
			end
			CMD_SWAP: begin
				if (!(a_ok && b_ok)) begin
					acc_rej = 1'b1;
				end else if (a_ext != b_ext) begin
					acc_state = S_READ;
				end
			end
			default: ;
		endcase
	end

	// ---------------- swap decision ----------------
	always_comb begin
		merged         = nbr_q;
		merged[last_q] = mem_rdata;
	end

	assign sum_a     = {1'b0, merged[SLOT_A_LO]} + {1'b0, merged[SLOT_A_HI]};
	assign sum_b     = {1'b0, merged[SLOT_B_LO]} + {1'b0, merged[SLOT_B_HI]};
	assign adjacent  = (a_q + LEN_W'(1) == b_q) || (b_q + LEN_W'(1) == a_q);
	assign a_below_b = a_q < b_q;
	// adjacent pair: outer neighbours are a-1/b+1 or b-1/a+1
	assign swap_ok   = adjacent ?
		(a_below_b ? (merged[SLOT_A_LO] == merged[SLOT_B_HI])
		           : (merged[SLOT_B_LO] == merged[SLOT_A_HI])) :
		(sum_a == sum_b);

	// ---------------- memory port ----------------
	always_comb begin
		addr_idx = a_q;
		if (state_q == S_READ) begin
			case (slot_q)
				SLOT_A_LO: addr_idx = a_q - LEN_W'(1);
				SLOT_A_HI: addr_idx = a_q + LEN_W'(1);
				SLOT_B_LO: addr_idx = b_q - LEN_W'(1);
				SLOT_B_HI: addr_idx = b_q + LEN_W'(1);
				SLOT_B:    addr_idx = b_q;
				default:   addr_idx = a_q;
			endcase
		end else if (state_q == S_WRITE && wr_second_q) begin
			addr_idx = b_q;
		end
	end

	assign addr_ext  = XW'(addr_idx);
	assign mem_addr  = addr_ext[AW-1:0];
	assign mem_we    = (state_q == S_WRITE);
	assign mem_wdata = wr_second_q ? wr_b_data_q : wr_a_data_q;

	bcts_chain_mem #(
		.DEPTH (MAX_LENGTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign out_load = (state_q == S_FIN) && (!out_valid_q || results.ready);

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cfg_len_q     <= RST_CHAIN_LENGTH;
			cfg_batch_q   <= RST_BATCH_ATTEMPTS;
			cnt_q         <= '0;
			cmd_q         <= CMD_WRITE;
			a_q           <= '0;
			b_q           <= '0;
			slot_q        <= '0;
			last_q        <= '0;
			wr_second_q   <= 1'b0;
			wr_a_data_q   <= 1'b0;
			wr_b_data_q   <= 1'b0;
			rd_vld_s1     <= 1'b0;
			rd_slot_s1    <= '0;
			nbr_q         <= '0;
			res_read_q    <= 1'b0;
			res_swapped_q <= 1'b0;
			res_rej_q     <= 1'b0;
			res_done_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_read_q    <= 1'b0;
			out_swapped_q <= 1'b0;
			out_rej_q     <= 1'b0;
			out_done_q    <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.reg_index)
					REG_CHAIN_LENGTH:   cfg_len_q   <= cfg.wr_data[LEN_W-1:0];
					REG_BATCH_ATTEMPTS: cfg_batch_q <= cfg.wr_data;
					default: ;
				endcase
			end

			rd_vld_s1  <= (state_q == S_READ);
			rd_slot_s1 <= slot_q;
			if (rd_vld_s1) begin
				nbr_q[rd_slot_s1] <= mem_rdata;
			end

			if (out_load) begin
				out_valid_q   <= 1'b1;
				out_read_q    <= res_read_q;
				out_swapped_q <= res_swapped_q;
				out_rej_q     <= res_rej_q;
				out_done_q    <= res_done_q;
			end else if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q         <= items.command;
						a_q           <= a_ext;
						b_q           <= b_ext;
						wr_a_data_q   <= items.bit_value;
						wr_second_q   <= 1'b0;
						res_read_q    <= 1'b0;
						res_swapped_q <= 1'b0;
						res_rej_q     <= acc_rej;
						res_done_q    <= (items.command == CMD_SWAP) && batch_hit;
						slot_q        <= acc_slot;
						last_q        <= acc_last;
						state_q       <= acc_state;
						if (items.command == CMD_SWAP) begin
							cnt_q <= batch_hit ? '0 : cnt_next;
						end
					end
				end
				S_READ: begin
					slot_q <= slot_q + 3'd1;
					if (slot_q == last_q) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (cmd_q == CMD_READ) begin
						res_read_q <= merged[SLOT_A];
						state_q    <= S_FIN;
					end else if (swap_ok) begin
						res_swapped_q <= 1'b1;
						wr_a_data_q   <= merged[SLOT_B];
						wr_b_data_q   <= merged[SLOT_A];
						state_q       <= S_WRITE;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_WRITE: begin
					if (cmd_q == CMD_WRITE || wr_second_q) begin
						state_q <= S_FIN;
					end else begin
						wr_second_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid      = out_valid_q;
	assign results.read_bit   = out_read_q;
	assign results.swapped    = out_swapped_q;
	assign results.rejected   = out_rej_q;
	assign results.batch_done = out_done_q;

	// ---------------- checks ----------------
	`BCTS_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != S_IDLE)
	`BCTS_ASSERT_IMP(a_eval_has_last_read, state_q == S_EVAL, rd_vld_s1 && rd_slot_s1 == last_q)
	`BCTS_ASSERT_IMP(a_swap_write_decided, state_q == S_WRITE && cmd_q == CMD_SWAP, res_swapped_q)
	`BCTS_ASSERT_IMP(a_result_exclusive, out_valid_q && (out_swapped_q || out_read_q), !out_rej_q)

endmodule

### tb/tb_binary_chain_transition_swap.sv
// Self-checking bench for binary_chain_transition_swap: a directed table, then
// randomised phases under several register settings, checked by a behavioural chain model.
// Depends on bcts_pkg and the bcts_in_if, bcts_out_if and bcts_cfg_if interfaces.
module tb_binary_chain_transition_swap import bcts_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_LEN     = DEF_MAX_LENGTH;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 24;

	localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic read_bit;
		logic swapped;
		logic rejected;
		logic batch_done;
	} outcome_t;

	localparam outcome_t OUT_QUIET       = 4'b0000;
	localparam outcome_t OUT_BIT_ONE     = 4'b1000;
	localparam outcome_t OUT_DONE        = 4'b0001;
	localparam outcome_t OUT_REJECT_DONE = 4'b0011;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic             v;
		logic             typed;
		outcome_t         want;
	} stim_row_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] len_data;
		logic [CFG_DATA_W-1:0] batch_data;
		logic [15:0]           count;
		logic                  spare_regs;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n;

	bcts_cfg_if cfg_ch ();
	bcts_in_if  items_ch ();
	bcts_out_if results_ch ();

	binary_chain_transition_swap dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (items_ch),
		.results (results_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Chain model
	bit          chain_bits [MAX_LEN];
	bit          written_bits [MAX_LEN];
	logic [15:0] attempt_count;
	logic [10:0] model_length;
	logic [15:0] model_batch;

	outcome_t expected_outcomes [$];

	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned n_items, n_reads, n_swapped, n_rejected, n_batches;
	int unsigned burst_left;

	stim_row_t directed_rows [25] = '{
		'{CMD_WRITE, 10'd0,    10'd0, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_READ,  10'd0,    10'd0, 1'b0, 1'b1, OUT_BIT_ONE},
		'{CMD_WRITE, 10'd1023, 10'd0, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_READ,  10'd1023, 10'd0, 1'b0, 1'b1, OUT_BIT_ONE},
		'{CMD_WRITE, 10'd1023, 10'd0, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_READ,  10'd1023, 10'd0, 1'b0, 1'b1, OUT_QUIET},
		'{CMD_WRITE, 10'd1,    10'd0, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_WRITE, 10'd2,    10'd0, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_WRITE, 10'd3,    10'd0, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_WRITE, 10'd4,    10'd0, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_WRITE, 10'd5,    10'd0, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_WRITE, 10'd6,    10'd0, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd2,    10'd4, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd1,    10'd4, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd2,    10'd3, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd5,    10'd4, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd0,    10'd5, 1'b0, 1'b1, OUT_REJECT_DONE},
		'{CMD_SWAP,  10'd3,    10'd1023, 1'b0, 1'b1, OUT_REJECT_DONE},
		'{CMD_WRITE, 10'd1021, 10'd0, 1'b1, 1'b0, OUT_QUIET},
		'{CMD_WRITE, 10'd1022, 10'd0, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd1022, 10'd1, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_SWAP,  10'd3,    10'd3, 1'b0, 1'b1, OUT_DONE},
		'{CMD_SPARE, 10'd1023, 10'd1023, 1'b1, 1'b1, OUT_QUIET},
		'{CMD_READ,  10'd2,    10'd0, 1'b0, 1'b0, OUT_QUIET},
		'{CMD_READ,  10'd4,    10'd0, 1'b0, 1'b0, OUT_QUIET}
	};

	// Lengths beyond the store are clipped; 0 in the batch register counts as 1.
	phase_t phases [9] = '{
		'{16'h0003, 16'h0001, 16'd100, 1'b0},
		'{16'hA010, 16'h0003, 16'd150, 1'b1},
		'{16'h0400, 16'h0007, 16'd150, 1'b0},
		'{16'h0000, 16'h0000, 16'd40,  1'b0},
		'{16'h0002, 16'h0002, 16'd40,  1'b0},
		'{16'hF7FF, 16'hFFFF, 16'd100, 1'b0},
		'{16'h0028, 16'h0005, 16'd150, 1'b0},
		'{16'h0009, 16'h0002, 16'd120, 1'b0},
		'{16'h0005, 16'h0001, 16'd50,  1'b0}
	};

	function automatic int unsigned chain_len();
		return (model_length < MAX_LEN) ? int'(model_length) : MAX_LEN;
	endfunction

	function automatic bit swap_in_range(int unsigned i, int unsigned len);
		return len >= 3 && i >= 1 && i <= len - 2;
	endfunction

	function automatic outcome_t predict_outcome(logic [CMD_W-1:0] cmd, int unsigned a,
			int unsigned b, bit v);
		outcome_t    o;
		int unsigned len, lo, hi, limit;
		bit          ok, t;
		o = OUT_QUIET;
		len = chain_len();
		case (cmd)
			CMD_WRITE: begin
				if (a < len) begin
					chain_bits[a] = v;
					written_bits[a] = 1'b1;
				end else begin
					o.rejected = 1'b1;
				end
			end
			CMD_READ: begin
				if (a < len)
					o.read_bit = chain_bits[a];
				else
					o.rejected = 1'b1;
			end
			CMD_SWAP: begin
				limit = (model_batch == 16'd0) ? 1 : int'(model_batch);
				if (!swap_in_range(a, len) || !swap_in_range(b, len)) begin
					o.rejected = 1'b1;
				end else if (a != b) begin
					lo = (a < b) ? a : b;
					hi = (a < b) ? b : a;
					if (hi - lo > 1)
						ok = (int'(chain_bits[a-1]) + int'(chain_bits[a+1])) ==
							(int'(chain_bits[b-1]) + int'(chain_bits[b+1]));
					else
						ok = chain_bits[lo-1] == chain_bits[hi+1];
					if (ok) begin
						t = chain_bits[a];
						chain_bits[a] = chain_bits[b];
						chain_bits[b] = t;
						o.swapped = 1'b1;
					end
				end
				attempt_count = attempt_count + 16'd1;
				if (attempt_count == 16'd0 || attempt_count >= limit) begin
					o.batch_done = 1'b1;
					attempt_count = 16'd0;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Bursty sender: a random gap opens each burst, some bursts have none.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
			logic v, logic typed, outcome_t want);
		int unsigned gap;
		outcome_t    predicted;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
			repeat (gap) begin
				@(negedge clk);
				items_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		items_ch.valid     <= 1'b1;
		items_ch.command   <= cmd;
		items_ch.index_a   <= a;
		items_ch.index_b   <= b;
		items_ch.bit_value <= v;
		do @(posedge clk); while (!items_ch.ready);
		predicted = predict_outcome(cmd, 32'(a), 32'(b), v);
		expected_outcomes.push_back(typed ? want : predicted);
		n_items++;
	endtask

	task automatic drain();
		@(negedge clk);
		items_ch.valid <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Leaves valid high; the caller lowers it after the last write.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wr_data   <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_CHAIN_LENGTH:   model_length = data[LEN_W-1:0];
			REG_BATCH_ATTEMPTS: model_batch = data;
			default: ;
		endcase
	endtask

	function automatic logic [IDX_W-1:0] pick_index(int unsigned len);
		int unsigned span;
		span = ((len < 1) ? 1 : len) + 1;
		if (span > 48)
			span = 48;
		if ($urandom_range(0, 3) == 0)
			return IDX_W'($urandom_range(0, MAX_LEN - 1));
		return IDX_W'($urandom_range(0, span - 1));
	endfunction

	// Random traffic for one phase; reads and swaps that would reach an unwritten
	// element are turned into a write of that element.
	task automatic run_random_phase(int unsigned count);
		int unsigned      done_items, roll, len, k, hole;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] a, b;
		logic             v;
		int unsigned      touch [6];
		done_items = 0;
		while (done_items < count) begin
			len = chain_len();
			roll = $urandom_range(0, 99);
			cmd = (roll < 30) ? CMD_WRITE : (roll < 75) ? CMD_SWAP :
				(roll < 93) ? CMD_READ : CMD_SPARE;
			a = pick_index(len);
			v = 1'($urandom_range(0, 1));
			roll = $urandom_range(0, 9);
			b = (roll < 3) ? a + 10'd1 : (roll < 5) ? a - 10'd1 : (roll == 5) ? a : pick_index(len);
			if (roll > 5 && $urandom_range(0, 4) == 0)
				b = IDX_W'($urandom_range(0, MAX_LEN - 1));
			hole = MAX_LEN;
			if (cmd == CMD_READ && a < len && !written_bits[a])
				hole = 32'(a);
			if (cmd == CMD_SWAP && swap_in_range(32'(a), len) && swap_in_range(32'(b), len) &&
					a != b) begin
				touch = '{32'(a) - 1, 32'(a), 32'(a) + 1, 32'(b) - 1, 32'(b), 32'(b) + 1};
				for (k = 0; k < 6; k++)
					if (hole == MAX_LEN && !written_bits[touch[k]])
						hole = touch[k];
			end
			if (hole != MAX_LEN) begin
				cmd = CMD_WRITE;
				a = IDX_W'(hole);
			end
			send_item(cmd, a, b, v, 1'b0, OUT_QUIET);
			if (cmd != CMD_SPARE)
				done_items++;
		end
	endtask

	// Receiver: a random ready pattern is chosen anew whenever stall_age runs out.
	int unsigned stall_mode, stall_age;
	always @(negedge clk) begin
		if (stall_age == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_age = 50;
		end
		stall_age--;
		case (stall_mode)
			0:       results_ch.ready <= 1'b1;
			1:       results_ch.ready <= ($urandom_range(0, 3) != 0);
			2:       results_ch.ready <= ($urandom_range(0, 7) == 0);
			default: results_ch.ready <= stall_age[1];
		endcase
	end

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			got = '{results_ch.read_bit, results_ch.swapped, results_ch.rejected,
				results_ch.batch_done};
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result %b (read/swap/rej/done)", $time, got);
				mismatches++;
			end else begin
				want = expected_outcomes.pop_front();
				if (got.read_bit !== want.read_bit)
					$display("%0t: read_bit expected %b actual %b", $time,
						want.read_bit, got.read_bit);
				if (got.swapped !== want.swapped)
					$display("%0t: swapped expected %b actual %b", $time,
						want.swapped, got.swapped);
				if (got.rejected !== want.rejected)
					$display("%0t: rejected expected %b actual %b", $time,
						want.rejected, got.rejected);
				if (got.batch_done !== want.batch_done)
					$display("%0t: batch_done expected %b actual %b", $time,
						want.batch_done, got.batch_done);
				if (got !== want)
					mismatches++;
				n_reads    += want.read_bit;
				n_swapped  += want.swapped;
				n_rejected += want.rejected;
				n_batches  += want.batch_done;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("cycle limit reached with %0d results outstanding", expected_outcomes.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned i;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_CHAIN_LENGTH;
		cfg_ch.wr_data = '0;
		items_ch.valid = 1'b0;
		items_ch.command = CMD_WRITE;
		items_ch.index_a = '0;
		items_ch.index_b = '0;
		items_ch.bit_value = 1'b0;
		burst_left = 0;
		attempt_count = '0;
		model_length = RST_CHAIN_LENGTH;
		model_batch = RST_BATCH_ATTEMPTS;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (i = 0; i < $size(directed_rows); i++)
			send_item(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
				directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want);

		for (i = 0; i < $size(phases); i++) begin
			drain();
			if (phases[i].spare_regs) begin
				write_register(REG_SPARE_A, 16'h5A5A);
				write_register(REG_SPARE_B, 16'hA5A5);
			end
			write_register(REG_CHAIN_LENGTH, phases[i].len_data);
			write_register(REG_BATCH_ATTEMPTS, phases[i].batch_data);
			@(negedge clk);
			cfg_ch.valid <= 1'b0;
			run_random_phase(32'(phases[i].count));
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d commands over %0d register settings: %0d ones read, %0d swaps, %0d rejects",
			n_items, $size(phases) + 1, n_reads, n_swapped, n_rejected);
		$display("%0d batches closed, %0d mismatching transfers", n_batches, mismatches);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
